### src/dq_pkg.sv
`default_nettype none
package dq_pkg;

  // Queue geometry.
  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Back-value reduction tree: cells are ORed in groups, then the groups.
  localparam int GRP_SIZE = 32;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Value reported when there is nothing to report.
  localparam logic [DATA_W-1:0] NONE_VALUE = {DATA_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_LOAD
  } dq_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic              shift_right;
    logic              shift_left;
    logic              write_back;
    logic [CNT_W-1:0]  wr_idx;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### src/dq_if.sv
`default_nettype none
interface dq_in_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, output kind, output value_in, input ready);
  modport sink   (input valid, input kind, input value_in, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     was_empty;
  logic                     overflow;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output popped_value, output was_empty, output overflow,
                  output count, output is_empty, output front_value, output back_value,
                  input ready);
  modport sink   (input valid, input popped_value, input was_empty, input overflow,
                  input count, input is_empty, input front_value, input back_value,
                  output ready);
endinterface
`default_nettype wire

### src/dq_cell.sv
`default_nettype none
module dq_cell (
  input  logic                       clk,
  input  dq_pkg::cell_ctrl_t         ctrl,
  input  logic [dq_pkg::CNT_W-1:0]   idx,
  input  logic [dq_pkg::CNT_W-1:0]   last_idx,
  input  logic [dq_pkg::DATA_W-1:0]  left_val,
  input  logic [dq_pkg::DATA_W-1:0]  right_val,
  output logic [dq_pkg::DATA_W-1:0]  val,
  output logic [dq_pkg::DATA_W-1:0]  tap
);
  import dq_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  // Push front moves every value one cell toward the back, pop front one
  // cell toward the front; push back writes only the cell just past the tail.
  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift_right) begin
      val_nxt = left_val;
    end else if (ctrl.shift_left) begin
      val_nxt = right_val;
    end else if (ctrl.write_back && (idx == ctrl.wr_idx)) begin
      val_nxt = ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign tap = (idx == last_idx) ? val_r : '0;

endmodule
`default_nettype wire

### src/dq_back_tree.sv
`default_nettype none
module dq_back_tree (
  input  logic                                      clk,
  input  logic [dq_pkg::CAPACITY-1:0][dq_pkg::DATA_W-1:0] taps,
  output logic [dq_pkg::DATA_W-1:0]                 back_or
);
  import dq_pkg::*;

  logic [NUM_GRP-1:0][DATA_W-1:0] grp_r;
  logic [NUM_GRP-1:0][DATA_W-1:0] grp_nxt;

  // At most one tap is nonzero, so an OR of all taps yields the tail value.
  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    back_or = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      back_or = back_or | grp_r[g];
    end
  end

endmodule
`default_nettype wire

### src/double_ended_queue.sv
`default_nettype none
// Channel   Role    Handshake      Payload
// in_ch     sink    valid/ready    kind, value_in
// out_ch    source  valid/ready    popped_value, was_empty, overflow, count,
//                                  is_empty, front_value, back_value
//
// Each transaction passes through acceptance and the cell-chain update, the first
// level of the back-value OR tree, then the result load.
// The next transaction is accepted once the previous one has reached the output
// register; while a result waits there, the next one holds in the load state
// and the input stalls. Reset (rst_n low, synchronous) empties the queue; cell
// contents are not cleared.
module double_ended_queue (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  // Control state.
  dq_state_t   state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // The tail value of the current contents, used by pop back.
  logic [DATA_W-1:0] back_r;

  // Per-transaction results held until the load step.
  logic [DATA_W-1:0] popped_hold_r, popped_nxt;
  logic              was_empty_hold_r, was_empty_nxt;
  logic              overflow_hold_r, overflow_nxt;

  // Output register.
  logic [DATA_W-1:0] out_popped_r, out_front_r, out_back_r;
  logic              out_was_empty_r, out_overflow_r, out_is_empty_r;
  logic [CNT_W-1:0]  out_count_r;

  logic        in_ready;
  logic        in_acc;
  logic        load_out;
  logic        is_full, is_empt;
  logic        op_push_f, op_push_b, op_pop_f, op_pop_b;
  cell_ctrl_t  ctrl;
  logic [CNT_W-1:0] last_idx;
  logic [DATA_W-1:0] tree_back;
  logic [DATA_W-1:0] cur_back;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_val;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_tap;

  assign in_acc  = in_ch.valid && in_ready;
  assign is_full = (cnt_r == CNT_W'(CAPACITY));
  assign is_empt = (cnt_r == '0);

  // Operation decode; unused codes behave as a peek.
  always_comb begin
    op_push_f = 1'b0;
    op_push_b = 1'b0;
    op_pop_f  = 1'b0;
    op_pop_b  = 1'b0;
    unique case (in_ch.kind)
      KIND_PUSH_FRONT: op_push_f = 1'b1;
      KIND_PUSH_BACK:  op_push_b = 1'b1;
      KIND_POP_FRONT:  op_pop_f  = 1'b1;
      KIND_POP_BACK:   op_pop_b  = 1'b1;
      default: ;
    endcase
  end

  // Commands to the chain. Pops from the back only shrink the count.
  always_comb begin
    ctrl.shift_right = in_acc && op_push_f && !is_full;
    ctrl.write_back  = in_acc && op_push_b && !is_full;
    ctrl.shift_left  = in_acc && op_pop_f && !is_empt;
    ctrl.wr_idx      = cnt_r;
    ctrl.data        = in_ch.value_in;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    popped_nxt    = NONE_VALUE;
    was_empty_nxt = 1'b0;
    overflow_nxt  = 1'b0;
    if (op_push_f || op_push_b) begin
      if (is_full) begin
        overflow_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (op_pop_f || op_pop_b) begin
      if (is_empt) begin
        was_empty_nxt = 1'b1;
      end else begin
        cnt_nxt    = cnt_r - CNT_W'(1);
        popped_nxt = op_pop_f ? cell_val[0] : back_r;
      end
    end
  end

  // The chain of cells: the front value always sits in cell 0.
  assign last_idx = cnt_r - CNT_W'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = ctrl.data;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (CNT_W'(i)),
      .last_idx  (last_idx),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .tap       (cell_tap[i])
    );
  end

  dq_back_tree u_back_tree (
    .clk     (clk),
    .taps    (cell_tap),
    .back_or (tree_back)
  );

  assign cur_back = is_empt ? NONE_VALUE : tree_back;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_REDUCE;
      S_REDUCE: state_nxt = S_LOAD;
      S_LOAD:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Output decode of the state machine.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_REDUCE: ;
      S_LOAD:   load_out = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      popped_hold_r    <= popped_nxt;
      was_empty_hold_r <= was_empty_nxt;
      overflow_hold_r  <= overflow_nxt;
    end
    if (load_out) begin
      back_r          <= cur_back;
      out_popped_r    <= popped_hold_r;
      out_was_empty_r <= was_empty_hold_r;
      out_overflow_r  <= overflow_hold_r;
      out_count_r     <= cnt_r;
      out_is_empty_r  <= is_empt;
      out_front_r     <= is_empt ? NONE_VALUE : cell_val[0];
      out_back_r      <= cur_back;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.was_empty    = out_was_empty_r;
  assign out_ch.overflow     = out_overflow_r;
  assign out_ch.count        = out_count_r;
  assign out_ch.is_empty     = out_is_empty_r;
  assign out_ch.front_value  = out_front_r;
  assign out_ch.back_value   = out_back_r;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  // A transaction always passes through the reduce state before its load.
  a_acc_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_REDUCE)
    else $error("accepted transaction skipped the reduce step");

  // A new result only appears out of the load state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOAD))
    else $error("result appeared outside the load step");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

  // A transaction cannot both underflow and overflow.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_was_empty_r && out_overflow_r))
    else $error("both empty and overflow flags set");

endmodule
`default_nettype wire
